// File: design/chpp_pkg.sv
// chpp_pkg: shared types and constants for the colon header packet parser
// command format passed from the front classifier to the back executor
// no dependencies
package chpp_pkg;

    localparam int BYTE_W      = 8;
    localparam int LIMIT_W     = 11;
    localparam int OUT_NUM_W   = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [BYTE_W-1:0]  COLON_CHAR    = 8'h3A;
    localparam logic [BYTE_W-1:0]  ZERO_CHAR     = 8'h30;
    localparam logic [BYTE_W-1:0]  NINE_CHAR     = 8'h39;
    localparam logic [LIMIT_W-1:0] DEFAULT_LIMIT = 11'd1000;

    localparam logic [1:0] OUT_NAME   = 2'd0;
    localparam logic [1:0] OUT_HEADER = 2'd1;
    localparam logic [1:0] OUT_DATA   = 2'd2;

    typedef enum logic [2:0] {
        CMD_NONE   = 3'd0,
        CMD_DIGIT  = 3'd1,
        CMD_NAME   = 3'd2,
        CMD_HEADER = 3'd3,
        CMD_DATA   = 3'd4
    } cmd_kind_t;

    typedef enum logic [1:0] {
        FIELD_TOTAL = 2'd0,
        FIELD_FRAG  = 2'd1,
        FIELD_SIZE  = 2'd2
    } field_t;

    typedef struct packed {
        logic              clear;
        cmd_kind_t         kind;
        field_t            field;
        logic [BYTE_W-1:0] data;
        logic              last;
    } cmd_t;

endpackage

// File: design/chpp_front.sv
// chpp_front: accepts packet bytes, tracks the parse phase and payload count
// and turns each beat that needs one into a command for the back part; holds the limit register
// depends on chpp_pkg
module chpp_front
    import chpp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [BYTE_W-1:0]  byte_in,
    input  logic               first_byte,
    input  logic               cfg_we,
    input  logic [LIMIT_W-1:0] data_byte_limit,
    input  logic               q_full,
    output logic               q_push,
    output cmd_t               q_cmd
);

    typedef enum logic [2:0] {
        PH_TOTAL = 3'd0,
        PH_FRAG  = 3'd1,
        PH_SIZE  = 3'd2,
        PH_NAME  = 3'd3,
        PH_DATA  = 3'd4,
        PH_DONE  = 3'd5
    } phase_t;

    phase_t             phase_reg;
    phase_t             phase_next;
    phase_t             phase_cur;
    logic               stopped_reg;
    logic               stopped_next;
    logic               stopped_cur;
    logic [LIMIT_W-1:0] count_reg;
    logic [LIMIT_W-1:0] count_next;
    logic [LIMIT_W-1:0] count_cur;
    logic [LIMIT_W-1:0] count_inc;
    logic [LIMIT_W-1:0] limit_reg;
    logic               accept;
    logic               is_colon;
    logic               is_digit;
    cmd_t               cmd;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign is_colon = (byte_in == COLON_CHAR);
    assign is_digit = (byte_in >= ZERO_CHAR) && (byte_in <= NINE_CHAR);

    always_comb
    begin
        phase_cur    = first_byte ? PH_TOTAL : phase_reg;
        stopped_cur  = first_byte ? 1'b0 : stopped_reg;
        count_cur    = first_byte ? '0 : count_reg;
        count_inc    = count_cur + 1'b1;
        phase_next   = phase_cur;
        stopped_next = stopped_cur;
        count_next   = count_cur;
        cmd.clear    = first_byte;
        cmd.kind     = CMD_NONE;
        cmd.field    = FIELD_TOTAL;
        cmd.data     = byte_in;
        cmd.last     = 1'b0;
        unique case (phase_cur)
            PH_TOTAL, PH_FRAG, PH_SIZE:
            begin
                if (phase_cur == PH_FRAG)
                begin
                    cmd.field = FIELD_FRAG;
                end
                else if (phase_cur == PH_SIZE)
                begin
                    cmd.field = FIELD_SIZE;
                end
                if (is_colon)
                begin
                    stopped_next = 1'b0;
                    if (phase_cur == PH_TOTAL)
                    begin
                        phase_next = PH_FRAG;
                    end
                    else if (phase_cur == PH_FRAG)
                    begin
                        phase_next = PH_SIZE;
                    end
                    else
                    begin
                        phase_next = PH_NAME;
                    end
                end
                else if (!stopped_cur && is_digit)
                begin
                    cmd.kind = CMD_DIGIT;
                end
                else
                begin
                    stopped_next = 1'b1;
                end
            end
            PH_NAME:
            begin
                if (is_colon)
                begin
                    cmd.kind   = CMD_HEADER;
                    count_next = '0;
                    phase_next = (limit_reg == '0) ? PH_DONE : PH_DATA;
                end
                else
                begin
                    cmd.kind = CMD_NAME;
                end
            end
            PH_DATA:
            begin
                count_next = count_inc;
                cmd.kind   = CMD_DATA;
                if (count_inc >= limit_reg)
                begin
                    cmd.last   = 1'b1;
                    phase_next = PH_DONE;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign q_cmd  = cmd;
    assign q_push = accept && ((cmd.kind != CMD_NONE) || cmd.clear);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_TOTAL;
            stopped_reg <= 1'b0;
            count_reg   <= '0;
            limit_reg   <= DEFAULT_LIMIT;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= data_byte_limit;
            end
            if (accept)
            begin
                phase_reg   <= phase_next;
                stopped_reg <= stopped_next;
                count_reg   <= count_next;
            end
        end
    end

endmodule

// File: design/chpp_queue.sv
// chpp_queue: short command queue between the front and back parts
// depends on chpp_pkg
module chpp_queue
    import chpp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t pop_cmd
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

    cmd_t             entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == DEPTH_CNT);
    assign not_empty = (count_reg != '0);
    assign pop_cmd   = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: design/chpp_back.sv
// chpp_back: executes queued commands, holds the three decimal accumulators
// and drives the registered result beat
// depends on chpp_pkg
module chpp_back
    import chpp_pkg::*;
#(
    parameter int NUMBER_WIDTH = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  cmd_t                 q_cmd,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           out_type,
    output logic [BYTE_W-1:0]    out_byte,
    output logic [OUT_NUM_W-1:0] total_fragments,
    output logic [OUT_NUM_W-1:0] fragment_number,
    output logic [OUT_NUM_W-1:0] payload_size,
    output logic                 last_payload
);

    localparam int WIDE_W = NUMBER_WIDTH + 4;

    logic [NUMBER_WIDTH-1:0] total_reg;
    logic [NUMBER_WIDTH-1:0] frag_reg;
    logic [NUMBER_WIDTH-1:0] size_reg;
    logic [NUMBER_WIDTH-1:0] acc_sel;
    logic [NUMBER_WIDTH-1:0] acc_base;
    logic [WIDE_W-1:0]       acc_wide;
    logic [NUMBER_WIDTH-1:0] acc_new;
    logic [OUT_NUM_W-1:0]    total_clip;
    logic [OUT_NUM_W-1:0]    frag_clip;
    logic [OUT_NUM_W-1:0]    size_clip;
    logic                    needs_out;
    logic                    out_free;
    logic                    load;

    logic                    out_valid_reg;
    logic [1:0]              type_reg;
    logic [BYTE_W-1:0]       byte_reg;
    logic [OUT_NUM_W-1:0]    total_out_reg;
    logic [OUT_NUM_W-1:0]    frag_out_reg;
    logic [OUT_NUM_W-1:0]    size_out_reg;
    logic                    last_reg;
    logic [1:0]              type_next;
    logic [BYTE_W-1:0]       byte_next;
    logic [OUT_NUM_W-1:0]    total_out_next;
    logic [OUT_NUM_W-1:0]    frag_out_next;
    logic [OUT_NUM_W-1:0]    size_out_next;
    logic                    last_next;

    assign needs_out = (q_cmd.kind == CMD_NAME) || (q_cmd.kind == CMD_HEADER)
                    || (q_cmd.kind == CMD_DATA);
    assign out_free  = !out_valid_reg || !out_stall;
    assign q_pop     = q_valid && (!needs_out || out_free);
    assign load      = q_pop && needs_out;

    // multiply by ten and add, saturating
    always_comb
    begin
        unique case (q_cmd.field)
            FIELD_FRAG: acc_sel = frag_reg;
            FIELD_SIZE: acc_sel = size_reg;
            default:    acc_sel = total_reg;
        endcase
        acc_base = q_cmd.clear ? '0 : acc_sel;
        acc_wide = ({4'b0, acc_base} << 3) + ({4'b0, acc_base} << 1)
                 + WIDE_W'(q_cmd.data[3:0]);
        acc_new  = (|acc_wide[WIDE_W-1:NUMBER_WIDTH]) ? '1 : acc_wide[NUMBER_WIDTH-1:0];
    end

    generate
        if (NUMBER_WIDTH > OUT_NUM_W)
        begin : g_clip
            assign total_clip = (|total_reg[NUMBER_WIDTH-1:OUT_NUM_W]) ? '1
                              : total_reg[OUT_NUM_W-1:0];
            assign frag_clip  = (|frag_reg[NUMBER_WIDTH-1:OUT_NUM_W]) ? '1
                              : frag_reg[OUT_NUM_W-1:0];
            assign size_clip  = (|size_reg[NUMBER_WIDTH-1:OUT_NUM_W]) ? '1
                              : size_reg[OUT_NUM_W-1:0];
        end
        else
        begin : g_extend
            assign total_clip = OUT_NUM_W'(total_reg);
            assign frag_clip  = OUT_NUM_W'(frag_reg);
            assign size_clip  = OUT_NUM_W'(size_reg);
        end
    endgenerate

    always_comb
    begin
        type_next      = OUT_NAME;
        byte_next      = q_cmd.data;
        total_out_next = '0;
        frag_out_next  = '0;
        size_out_next  = '0;
        last_next      = 1'b0;
        unique case (q_cmd.kind)
            CMD_HEADER:
            begin
                type_next      = OUT_HEADER;
                byte_next      = '0;
                total_out_next = total_clip;
                frag_out_next  = frag_clip;
                size_out_next  = size_clip;
            end
            CMD_DATA:
            begin
                type_next = OUT_DATA;
                last_next = q_cmd.last;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            frag_reg      <= '0;
            size_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                // a restart beat always belongs to the total field
                if (q_cmd.clear)
                begin
                    total_reg <= (q_cmd.kind == CMD_DIGIT) ? acc_new : '0;
                    frag_reg  <= '0;
                    size_reg  <= '0;
                end
                else if (q_cmd.kind == CMD_DIGIT)
                begin
                    unique case (q_cmd.field)
                        FIELD_FRAG: frag_reg  <= acc_new;
                        FIELD_SIZE: size_reg  <= acc_new;
                        default:    total_reg <= acc_new;
                    endcase
                end
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            type_reg      <= type_next;
            byte_reg      <= byte_next;
            total_out_reg <= total_out_next;
            frag_out_reg  <= frag_out_next;
            size_out_reg  <= size_out_next;
            last_reg      <= last_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_type        = type_reg;
    assign out_byte        = byte_reg;
    assign total_fragments = total_out_reg;
    assign fragment_number = frag_out_reg;
    assign payload_size    = size_out_reg;
    assign last_payload    = last_reg;

endmodule

// File: design/colon_header_packet_parser.sv
// colon_header_packet_parser: byte-wide parser for total:frag:size:name:data packets
// one beat accepted per cycle while the two-entry command queue has room
// a result beat passes through the command queue and then the output register; a stall can hold it in either
// the back part retires one command per cycle while one is queued; name, header and data need the output register free
// reset clears parse state, accumulators, queue and output valid; limit returns to 1000
// depends on chpp_pkg, chpp_front, chpp_queue, chpp_back
module colon_header_packet_parser
    import chpp_pkg::*;
#(
    parameter int NUMBER_WIDTH = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [LIMIT_W-1:0]   data_byte_limit,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [BYTE_W-1:0]    byte_in,
    input  logic                 first_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           out_type,
    output logic [BYTE_W-1:0]    out_byte,
    output logic [OUT_NUM_W-1:0] total_fragments,
    output logic [OUT_NUM_W-1:0] fragment_number,
    output logic [OUT_NUM_W-1:0] payload_size,
    output logic                 last_payload
);

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    cmd_t push_cmd;
    cmd_t pop_cmd;

    chpp_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .byte_in         (byte_in),
        .first_byte      (first_byte),
        .cfg_we          (cfg_we),
        .data_byte_limit (data_byte_limit),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_cmd           (push_cmd)
    );

    chpp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_cmd   (pop_cmd)
    );

    chpp_back #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_cmd           (pop_cmd),
        .q_pop           (q_pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_type        (out_type),
        .out_byte        (out_byte),
        .total_fragments (total_fragments),
        .fragment_number (fragment_number),
        .payload_size    (payload_size),
        .last_payload    (last_payload)
    );

endmodule

// File: design/chpp_checker.sv
// chpp_checker: port-level checks on the parser's result channel, bound to the top
// depends on chpp_pkg and colon_header_packet_parser
module chpp_checker
    import chpp_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [1:0]           out_type,
    input logic [BYTE_W-1:0]    out_byte,
    input logic [OUT_NUM_W-1:0] total_fragments,
    input logic [OUT_NUM_W-1:0] fragment_number,
    input logic [OUT_NUM_W-1:0] payload_size,
    input logic                 last_payload
);

    // stalled beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_type) && $stable(out_byte)
            && $stable(total_fragments) && $stable(fragment_number)
            && $stable(payload_size) && $stable(last_payload))
        else $error("result beat changed while stalled");

    a_header_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_type == OUT_HEADER) |-> (out_byte == '0) && !last_payload)
        else $error("header beat carries byte or last mark");

    a_numbers_only_in_header: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_type != OUT_HEADER)
            |-> (total_fragments == '0) && (fragment_number == '0) && (payload_size == '0))
        else $error("numbers set outside header beat");

    a_last_on_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_payload |-> (out_type == OUT_DATA))
        else $error("last mark on non-payload beat");

endmodule

bind colon_header_packet_parser chpp_checker u_chpp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_type        (out_type),
    .out_byte        (out_byte),
    .total_fragments (total_fragments),
    .fragment_number (fragment_number),
    .payload_size    (payload_size),
    .last_payload    (last_payload)
);
